@@ rtl/scra_pkg.sv @@
// Package for the SPI command register access core.
// Holds store sizing, command codes and the phase and control state types.
// No dependencies; compile first.
package scra_pkg;

  localparam int ADDR_WIDTH  = 8;
  localparam int STORE_DEPTH = 1 << ADDR_WIDTH;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] CMD_READ   = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_TOGGLE = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_SET    = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h10;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [ADDR_WIDTH-1:0] addr_t;

  // Transaction phase
  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_ADDR  = 2'd1,
    PH_DATA  = 2'd2,
    PH_DUMMY = 2'd3
  } phase_t;

  // Item sequencer
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_t;

  function automatic logic is_modify_cmd(input byte_t c);
    return (c == CMD_WRITE) || (c == CMD_TOGGLE) || (c == CMD_SET) || (c == CMD_CLEAR);
  endfunction

endpackage

@@ rtl/scra_in_if.sv @@
// Received-byte channel: valid/ready handshake carrying one SPI byte.
// Depends on scra_pkg.
interface scra_in_if;
  logic                  valid;
  logic                  ready;
  scra_pkg::byte_t       rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/scra_out_if.sv @@
// Reply-byte channel: valid/ready handshake carrying the next byte to shift out.
// Depends on scra_pkg.
interface scra_out_if;
  logic                  valid;
  logic                  ready;
  scra_pkg::byte_t       tx_byte;

  modport source (output valid, output tx_byte, input ready);
  modport sink   (input valid, input tx_byte, output ready);
endinterface

@@ rtl/spi_command_register_access_core.sv @@
// SPI command register access core: command decode and a 256-byte register store.
// Depends on scra_pkg, scra_in_if and scra_out_if.
//
//   channel   dir  handshake      payload
//   in_word   in   valid/ready    rx_byte [7:0]  byte received from the master
//   out_word  out  valid/ready    tx_byte [7:0]  byte to load for the next transfer
//
// Each word is accepted in the idle state, which issues the store read, and is
// executed in the execute state, which writes back and loads the reply register;
// no word is taken during execute. Synchronous active-low reset clears control
// state, phase, command, address, reply valid and the per-entry valid bits at
// once, so the store reads as zero with no clearing pass. A waiting reply stalls
// the input only if it is not taken in the cycle a new word would be accepted.
module spi_command_register_access_core (
  input  logic        clk,
  input  logic        rst_n,
  scra_in_if.sink     in_word,
  scra_out_if.source  out_word
);
  import scra_pkg::*;

  // Control and transaction state
  ctl_state_t ctl_r, ctl_nxt;
  phase_t     phase_r, phase_nxt;
  byte_t      cmd_r, cmd_nxt;
  addr_t      addr_r, addr_nxt;
  byte_t      rx_r;

  // Register store: data array plus a valid bit per entry
  byte_t                  store_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  byte_t                  rd_data_r;
  logic                   rd_vld_r;
  addr_t                  rd_addr;
  logic                   mem_we;
  byte_t                  wr_data;

  // Reply register
  logic  out_valid_r, out_valid_nxt;
  byte_t out_data_r;
  byte_t tx_nxt;

  logic  in_acc;
  byte_t cur;

  assign in_acc = in_word.valid && in_word.ready;

  // Address-phase words index the store directly; a data word uses the held address
  assign rd_addr = (phase_r == PH_ADDR) ? in_word.rx_byte[ADDR_WIDTH-1:0] : addr_r;

  // Next-state logic
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      CS_IDLE: if (in_acc) ctl_nxt = CS_EXEC;
      CS_EXEC: ctl_nxt = CS_IDLE;
      default: ctl_nxt = CS_IDLE;
    endcase
  end

  // Handshake outputs: take a word only when idle and the reply slot drains in time
  always_comb begin
    in_word.ready = 1'b0;
    case (ctl_r)
      CS_IDLE: in_word.ready = !out_valid_r || out_word.ready;
      CS_EXEC: in_word.ready = 1'b0;
      default: in_word.ready = 1'b0;
    endcase
  end

  assign out_word.valid   = out_valid_r;
  assign out_word.tx_byte = out_data_r;

  // Execute: decode the held word against the phase and the read-back entry
  always_comb begin
    cur       = rd_vld_r ? rd_data_r : '0;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    tx_nxt    = '0;
    mem_we    = 1'b0;
    wr_data   = cur;
    if (ctl_r == CS_EXEC) begin
      case (phase_r)
        PH_CMD: begin
          cmd_nxt   = rx_r;
          phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          if (cmd_r == CMD_READ) begin
            addr_nxt  = rx_r[ADDR_WIDTH-1:0];
            tx_nxt    = cur;
            phase_nxt = PH_DUMMY;
          end else if (is_modify_cmd(cmd_r)) begin
            addr_nxt  = rx_r[ADDR_WIDTH-1:0];
            phase_nxt = PH_DATA;
          end else begin
            // unknown command: drop back to awaiting a command
            phase_nxt = PH_CMD;
          end
        end
        PH_DATA: begin
          case (cmd_r)
            CMD_WRITE:  wr_data = rx_r;
            CMD_TOGGLE: wr_data = cur ^ rx_r;
            CMD_SET:    wr_data = cur | rx_r;
            CMD_CLEAR:  wr_data = cur & ~rx_r;
            default:    wr_data = cur;
          endcase
          mem_we    = 1'b1;
          phase_nxt = PH_CMD;
        end
        PH_DUMMY: phase_nxt = PH_CMD;
        default:  phase_nxt = PH_CMD;
      endcase
    end
  end

  // Reply slot: load on execute, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl_r == CS_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= CS_IDLE;
      phase_r     <= PH_CMD;
      cmd_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) vld_r[addr_r] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rx_r     <= in_word.rx_byte;
      rd_vld_r <= vld_r[rd_addr];
    end
    if (ctl_r == CS_EXEC) out_data_r <= tx_nxt;
  end

  // Store: one write port, one registered read port. The write lands at the
  // execute edge, always before the next word's read, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[addr_r] <= wr_data;
    if (in_acc) rd_data_r <= store_mem[rd_addr];
  end

  // Every accepted word is executed on the following edge
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (ctl_r == CS_EXEC))
    else $error("accepted word not executed");

  // Execution always leaves a reply in the output slot
  a_exec_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CS_EXEC) |=> out_valid_r)
    else $error("executed word left no reply");

  // Only the address word of a read can produce a non-zero reply
  a_reply_src: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctl_r == CS_EXEC) && (tx_nxt != '0)) |-> ((phase_r == PH_ADDR) && (cmd_r == CMD_READ)))
    else $error("non-zero reply outside a read");

  // A store write, made only on a data word, returns the phase to awaiting a command
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (phase_r == PH_CMD))
    else $error("store write without return to command phase");

endmodule
